// ----- rtl/ptts_pkg.sv -----
// shared types, codes and defaults for the periodic task table scheduler
// no dependencies; used by every module in rtl/
package ptts_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int ID_W        = 8;
    localparam int TICK_W      = 32;
    localparam int CNT_OUT_W   = 7;

    // operation selector carried in the input tuser
    typedef enum logic [1:0] {
        FUNC_SET      = 2'd0,
        FUNC_DELETE   = 2'd1,
        FUNC_DISPATCH = 2'd2,
        FUNC_TICK     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_NULL_ID   = 2'd3
    } t_status;

    // one row of the task table
    typedef struct packed {
        logic              run;
        logic [TICK_W-1:0] period;
        logic [TICK_W-1:0] delay;
        logic [ID_W-1:0]   id;
    } t_entry;

    // flags and result of the shared decrement unit
    typedef struct packed {
        logic              delay_zero;
        logic              period_zero;
        logic [TICK_W-1:0] dec;
    } t_alu_res;

endpackage

// ----- rtl/periodic_task_table_scheduler_core.sv -----
// periodic task table scheduler: sequencer, table walk and result output register
// depends on ptts_pkg, ptts_alu, ptts_table, ptts_rbuf
//
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: task_id, delay_ticks, period_ticks
//                                                tuser: func
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: run_task, status, task_count,
//                                                tick_count; tuser: run_valid; tlast: last
//
// one item walks the table entry by entry, each entry read (S_RD), then acted on (S_CMP),
// through the table's one read and one write port and one shared decrement unit; an
// entry that is moved into a hole takes an extra S_MOVE step. results are then read
// back one by one, each through S_OUT_RD and S_OUT_LD. ready is high only while the
// sequencer is idle; the last result may still sit in the output register while the
// next item is taken. stalls on m_axis hold the sequencer.
// reset (synchronous, active low) empties the table and zeroes the tick count; the
// table memory itself is not cleared, only entries below the count are ever used.
module periodic_task_table_scheduler_core #(
    parameter int DEPTH = ptts_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // task_id[7:0], delay_ticks[39:8], period_ticks[71:40]
    input  logic [1:0]  s_axis_tuser,  // func[1:0]
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // run_task[7:0], status[9:8], task_count[16:10],
                                       // tick_count[48:17], zero fill[55:49]
    output logic        m_axis_tuser,  // run_valid
    output logic        m_axis_tlast   // last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = ptts_pkg::TICK_W;
    localparam int IW = ptts_pkg::ID_W;

    // one-hot sequencer states
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_RD     = 6'b000010,
        S_CMP    = 6'b000100,
        S_MOVE   = 6'b001000,
        S_OUT_RD = 6'b010000,
        S_OUT_LD = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;   // entries in use
    logic [TW-1:0]     r_ticks, n_ticks;   // wrapping tick counter
    logic [CW-1:0]     r_k, n_k;           // scan position
    logic [CW-1:0]     r_n, n_n;           // ids collected in a dispatch pass
    logic [CW-1:0]     r_e, n_e;           // result being emitted
    ptts_pkg::t_status r_status, n_status;
    logic              r_m_valid, n_m_valid;

    // captured item
    ptts_pkg::t_func   r_func;
    logic [IW-1:0]     r_id;
    logic [TW-1:0]     r_dly;
    logic [TW-1:0]     r_per;

    // output register payload
    logic [IW-1:0]     r_m_task;
    logic              r_m_rv;
    ptts_pkg::t_status r_m_status;
    logic [CW-1:0]     r_m_cnt;
    logic [TW-1:0]     r_m_ticks;
    logic              r_m_last;

    // table and buffer ports
    logic              tab_we;
    logic [AW-1:0]     tab_waddr;
    ptts_pkg::t_entry  tab_wdata;
    logic [AW-1:0]     tab_raddr;
    ptts_pkg::t_entry  tab_rdata;
    logic              buf_we;
    logic [IW-1:0]     buf_rdata;
    ptts_pkg::t_alu_res alu_res;

    logic              in_acc;
    logic              out_free;
    logic              scan_end;
    logic              has_ids;
    logic              is_last;
    logic              out_load;
    logic [CW-1:0]     tail;
    logic [CW-1:0]     nres;
    ptts_pkg::t_func   in_func;
    logic [IW-1:0]     in_id;

    assign in_func  = ptts_pkg::t_func'(s_axis_tuser);
    assign in_id    = s_axis_tdata[7:0];
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;
    assign tail     = r_count - CW'(1);
    // a one-shot removal at the tail steps past the shrunken count
    assign scan_end = (r_k >= r_count);
    assign has_ids  = (r_func == ptts_pkg::FUNC_DISPATCH) && (r_n != '0);
    assign nres     = has_ids ? r_n : CW'(1);
    assign is_last  = (r_e == nres - CW'(1));

    ptts_alu u_alu (
        .i_delay      (tab_rdata.delay),
        .i_period     (tab_rdata.period),
        .i_use_period (r_func == ptts_pkg::FUNC_DISPATCH),
        .o_res        (alu_res)
    );

    ptts_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    ptts_rbuf #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_rbuf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (r_n[AW-1:0]),
        .i_wdata (tab_rdata.id),
        .i_raddr (r_e[AW-1:0]),
        .o_rdata (buf_rdata)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ticks   = r_ticks;
        n_k       = r_k;
        n_n       = r_n;
        n_e       = r_e;
        n_status  = r_status;
        n_m_valid = r_m_valid && !m_axis_tready;
        out_load  = 1'b0;
        tab_we    = 1'b0;
        tab_waddr = r_k[AW-1:0];
        tab_wdata = tab_rdata;
        tab_raddr = r_k[AW-1:0];
        buf_we    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_k      = '0;
                    n_n      = '0;
                    n_e      = '0;
                    n_status = ptts_pkg::ST_OK;
                    n_state  = S_RD;
                    if (in_func == ptts_pkg::FUNC_TICK) begin
                        n_ticks = r_ticks + TW'(1);
                    end
                    if ((in_func == ptts_pkg::FUNC_SET || in_func == ptts_pkg::FUNC_DELETE)
                            && in_id == '0) begin
                        n_status = ptts_pkg::ST_NULL_ID;
                        n_state  = S_OUT_RD;
                    end
                end
            end
            S_RD: begin
                if (scan_end) begin
                    n_state = S_OUT_RD;
                    case (r_func)
                        ptts_pkg::FUNC_SET: begin
                            if (r_count < CW'(DEPTH)) begin
                                // append the new task stopped
                                tab_we    = 1'b1;
                                tab_waddr = r_count[AW-1:0];
                                tab_wdata = '{run: 1'b0, period: r_per, delay: r_dly,
                                              id: r_id};
                                n_count   = r_count + CW'(1);
                            end else begin
                                n_status = ptts_pkg::ST_FULL;
                            end
                        end
                        ptts_pkg::FUNC_DELETE: begin
                            n_status = ptts_pkg::ST_NOT_FOUND;
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                // fetch the tail entry in case this slot is vacated
                tab_raddr = tail[AW-1:0];
                n_k       = r_k + CW'(1);
                n_state   = S_RD;
                case (r_func)
                    ptts_pkg::FUNC_SET: begin
                        if (tab_rdata.id == r_id) begin
                            tab_we    = 1'b1;
                            tab_wdata = '{run: 1'b0, period: r_per, delay: r_dly, id: r_id};
                            n_state   = S_OUT_RD;
                        end
                    end
                    ptts_pkg::FUNC_DELETE: begin
                        if (tab_rdata.id == r_id) begin
                            if (r_k == tail) begin
                                n_count = tail;
                                n_state = S_OUT_RD;
                            end else begin
                                n_k     = r_k;
                                n_state = S_MOVE;
                            end
                        end
                    end
                    ptts_pkg::FUNC_DISPATCH: begin
                        if (tab_rdata.run) begin
                            buf_we = 1'b1;
                            n_n    = r_n + CW'(1);
                            if (alu_res.period_zero) begin
                                // one-shot task leaves the table
                                if (r_k == tail) begin
                                    n_count = tail;
                                end else begin
                                    n_k     = r_k;
                                    n_state = S_MOVE;
                                end
                            end else begin
                                tab_we         = 1'b1;
                                tab_wdata.run  = 1'b0;
                                if (alu_res.delay_zero) begin
                                    tab_wdata.delay = alu_res.dec;
                                end
                            end
                        end
                    end
                    default: begin
                        // timer tick: flag due tasks, count the rest down
                        tab_we = 1'b1;
                        if (alu_res.delay_zero) begin
                            tab_wdata.run = 1'b1;
                        end else begin
                            tab_wdata.delay = alu_res.dec;
                        end
                    end
                endcase
            end
            S_MOVE: begin
                // tail entry fills the hole; it is not looked at again this pass
                tab_we  = 1'b1;
                n_count = tail;
                if (r_func == ptts_pkg::FUNC_DELETE) begin
                    n_state = S_OUT_RD;
                end else begin
                    n_k     = r_k + CW'(1);
                    n_state = S_RD;
                end
            end
            S_OUT_RD: begin
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    n_m_valid = 1'b1;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_e     = r_e + CW'(1);
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ticks   <= '0;
            r_k       <= '0;
            r_n       <= '0;
            r_e       <= '0;
            r_status  <= ptts_pkg::ST_OK;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ticks   <= n_ticks;
            r_k       <= n_k;
            r_n       <= n_n;
            r_e       <= n_e;
            r_status  <= n_status;
            r_m_valid <= n_m_valid;
        end
    end

    // item capture and output payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func <= in_func;
            r_id   <= in_id;
            r_dly  <= s_axis_tdata[39:8];
            r_per  <= s_axis_tdata[71:40];
        end
        if (out_load) begin
            r_m_task   <= has_ids ? buf_rdata : '0;
            r_m_rv     <= has_ids;
            r_m_status <= r_status;
            r_m_cnt    <= r_count;
            r_m_ticks  <= r_ticks;
            r_m_last   <= is_last;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'd0, r_m_ticks, ptts_pkg::CNT_OUT_W'(r_m_cnt), r_m_status,
                            r_m_task};
    assign m_axis_tuser  = r_m_rv;
    assign m_axis_tlast  = r_m_last;

`ifndef SYNTHESIS
    // table never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("task count beyond table depth");

    // sequencer state stays one-hot
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    // a tick item advances the tick counter by exactly one
    a_tick_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_func == ptts_pkg::FUNC_TICK) |=> r_ticks == $past(r_ticks) + TW'(1))
        else $error("tick counter did not advance");

    // a result is loaded only when the output register is free or being drained
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_m_valid || m_axis_tready))
        else $error("pending result overwritten");
`endif

endmodule

// ----- rtl/ptts_alu.sv -----
// shared zero test and decrement unit for delay and period words
// depends on ptts_pkg
module ptts_alu (
    input  logic [ptts_pkg::TICK_W-1:0] i_delay,
    input  logic [ptts_pkg::TICK_W-1:0] i_period,
    input  logic                        i_use_period,
    output ptts_pkg::t_alu_res          o_res
);

    logic [ptts_pkg::TICK_W-1:0] operand;

    always_comb begin
        operand           = i_use_period ? i_period : i_delay;
        o_res.delay_zero  = (i_delay == '0);
        o_res.period_zero = (i_period == '0);
        o_res.dec         = operand - ptts_pkg::TICK_W'(1);
    end

endmodule

// ----- rtl/ptts_table.sv -----
// task table memory, one write port and one registered read port
// depends on ptts_pkg
module ptts_table #(
    parameter int DEPTH = ptts_pkg::DEPTH_DEF,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  ptts_pkg::t_entry  i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output ptts_pkg::t_entry  o_rdata
);

    ptts_pkg::t_entry mem [DEPTH];
    ptts_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ptts_rbuf.sv -----
// buffer of task ids found ready during a dispatch pass, read back in order
// depends on ptts_pkg
module ptts_rbuf #(
    parameter int DEPTH = ptts_pkg::DEPTH_DEF,
    parameter int AW    = 4
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [ptts_pkg::ID_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [ptts_pkg::ID_W-1:0] o_rdata
);

    logic [ptts_pkg::ID_W-1:0] mem [DEPTH];
    logic [ptts_pkg::ID_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
